// File: design/kvt_pkg.sv
// shared types and constants of the key-value table
`default_nettype none

package kvt_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned IDX_W       = $clog2(CAPACITY);
  localparam int unsigned FILL_W      = $clog2(CAPACITY + 1);
  localparam int unsigned LIMIT_W     = 5;
  localparam int unsigned CMP_W       = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } kvt_status_e;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_SET    = 1'b1
  } kvt_op_e;

  typedef struct packed {
    logic              operation;
    logic [KEY_W-1:0]  search_key;
    logic [31:0]       new_value;
    logic              write_enable;
  } kvt_in_t;

  typedef struct packed {
    kvt_status_e status;
    logic [3:0]  entry_index;
    logic [31:0] value_out;
  } kvt_out_t;

  // query token walking down the cell chain
  typedef struct packed {
    logic                   vld;
    logic                   done;
    kvt_op_e                op;
    logic [KEY_W-1:0]       key;
    logic [VALUE_WIDTH-1:0] value;
    logic                   we;
    logic                   room;
    kvt_status_e            status;
    logic [IDX_W-1:0]       idx;
  } kvt_token_t;

endpackage

`default_nettype wire

// File: design/kvt_cell.sv
// one table entry with its own key compare and a token register
`default_nettype none

module kvt_cell
  import kvt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic [IDX_W-1:0] cell_idx_i,
  input  wire kvt_token_t       tok_i,
  output      kvt_token_t       tok_o
);

  kvt_token_t             tok_q;
  logic                   occ_q, occ_d;
  logic [KEY_W-1:0]       key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic                   key_we, val_we;
  logic                   live, hit, empty_here;

  assign live       = tok_q.vld && !tok_q.done;
  assign hit        = live && occ_q && (key_q == tok_q.key);
  assign empty_here = live && !occ_q;

  always_comb begin
    tok_o  = tok_q;
    occ_d  = occ_q;
    key_we = 1'b0;
    val_we = 1'b0;
    if (hit) begin
      tok_o.done   = 1'b1;
      tok_o.status = ST_FOUND;
      tok_o.idx    = cell_idx_i;
      if (tok_q.op == OP_SET && tok_q.we) begin
        val_we = 1'b1;
      end else begin
        tok_o.value = value_q;
      end
    end else if (empty_here) begin
      // first free entry ends the filled region
      tok_o.done = 1'b1;
      if (tok_q.op == OP_LOOKUP) begin
        tok_o.status = ST_NOT_FOUND;
        tok_o.idx    = '0;
        tok_o.value  = '0;
      end else if (!tok_q.room) begin
        tok_o.status = ST_FULL;
        tok_o.idx    = '0;
        tok_o.value  = '0;
      end else begin
        tok_o.status = ST_INSERTED;
        tok_o.idx    = cell_idx_i;
        key_we       = 1'b1;
        occ_d        = 1'b1;
        if (tok_q.we) begin
          val_we = 1'b1;
        end else begin
          tok_o.value = value_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      occ_q <= 1'b0;
    end else if (adv_i) begin
      tok_q <= tok_i;
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && key_we) begin
      key_q <= tok_q.key;
    end
    if (adv_i && val_we) begin
      value_q <= tok_q.value;
    end
  end

endmodule

`default_nettype wire

// File: design/key_value_table_core.sv
// top level of the key-value table: cell chain, fill count, limit and output register
`default_nettype none

// Fully associative key-value table of CAPACITY entries (64-bit keys, VALUE_WIDTH-bit values),
// filled in order. An accepted item becomes a token that walks down a chain of CAPACITY cells,
// one cell per clock while the chain is not held; each cell compares the key against its own
// entry, so the lowest matching index wins, and the first empty cell either reports not found,
// inserts the pair, or reports full once the fill count reaches min(table_limit, CAPACITY).
// A token that passes every cell without resolving is a miss on a completely full table. Only
// one item is in the chain at a time: a new item is accepted the cycle after the previous
// result is loaded into the output register. The output register lets a new item enter while
// an earlier result still waits; if a result reaches the end of the chain while the register
// is still full, the chain holds. table_limit resets to 16 and may be written whenever the
// block is idle. Values of entries that were reserved with write_enable low and never written
// are undefined when read.
module key_value_table_core
  import kvt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire kvt_in_t            in_item_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      kvt_out_t           out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic [LIMIT_W-1:0] cfg_wdata_i
);

  // token chain: tok[0] enters cell 0, tok[g+1] leaves cell g
  kvt_token_t          tok [CAPACITY+1];
  logic [CAPACITY-1:0] tok_vld;

  logic               busy_q, busy_d;
  logic               out_vld_q, out_vld_d;
  kvt_out_t           out_q, out_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [CMP_W-1:0]   limit_eff, fill_ext;
  logic               accept, adv, load, room;
  kvt_token_t         exit_tok;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = !busy_q;

  // usable limit is the lower of the register and the capacity
  assign limit_eff = (CMP_W'(limit_q) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY)
                                                          : CMP_W'(limit_q);
  assign fill_ext  = CMP_W'(fill_q);
  assign room      = fill_ext < limit_eff;

  // new token for cell 0
  always_comb begin
    tok[0]        = '0;
    tok[0].vld    = accept;
    tok[0].op     = kvt_op_e'(in_item_i.operation);
    tok[0].key    = in_item_i.search_key;
    tok[0].value  = VALUE_WIDTH'(in_item_i.new_value);
    tok[0].we     = in_item_i.write_enable;
    tok[0].room   = room;
    tok[0].status = ST_FOUND;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_chain
    kvt_cell u_kvt_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .cell_idx_i (IDX_W'(g)),
      .tok_i      (tok[g]),
      .tok_o      (tok[g+1])
    );
    assign tok_vld[g] = tok[g+1].vld;
  end

  assign exit_tok = tok[CAPACITY];

  // hold the chain while a finished token cannot enter the output register
  assign adv  = !(exit_tok.vld && out_vld_q && !out_ready_i);
  assign load = exit_tok.vld && adv;

  // result of the token leaving the last cell
  always_comb begin
    out_d = out_q;
    if (exit_tok.done) begin
      out_d.status      = exit_tok.status;
      out_d.entry_index = 4'(exit_tok.idx);
      out_d.value_out   = 32'(exit_tok.value);
    end else begin
      // missed every entry of a completely filled table
      out_d.status      = (exit_tok.op == OP_SET) ? ST_FULL : ST_NOT_FOUND;
      out_d.entry_index = '0;
      out_d.value_out   = '0;
    end
  end

  always_comb begin
    busy_d    = busy_q;
    out_vld_d = out_vld_q;
    fill_d    = fill_q;
    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (load) begin
      out_vld_d = 1'b1;
      busy_d    = 1'b0;
      if (exit_tok.done && exit_tok.status == ST_INSERTED) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
    if (accept) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
      fill_q    <= '0;
      limit_q   <= LIMIT_W'(16);
    end else begin
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
      fill_q    <= fill_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // at most one token in the chain at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(tok_vld))
    else $error("more than one token in the cell chain");

  // busy exactly while a token is in the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q == (|tok_vld))
    else $error("busy flag disagrees with the cell chain");

  // an insert never happens on a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && exit_tok.done && exit_tok.status == ST_INSERTED) |->
      (CMP_W'(fill_q) < CMP_W'(CAPACITY)))
    else $error("insert beyond capacity");

  // fill count only moves by one on an insert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + FILL_W'(1)))
    else $error("fill count jumped");

endmodule

`default_nettype wire
